FILE: rtl/psfp_pkg.sv
`timescale 1ns / 1ps

package psfp_pkg;

	localparam logic [7:0] START_MARKER = 8'h42;

	localparam int unsigned PM25_HI_POS = 6;
	localparam int unsigned PM25_LO_POS = 7;
	localparam int unsigned PM10_HI_POS = 8;
	localparam int unsigned PM10_LO_POS = 9;

	typedef struct packed {
		logic        done;
		logic        ok;
		logic [15:0] pm2_5;
		logic [15:0] pm10;
	} frame_result_t;

endpackage

FILE: rtl/psfp_frame.sv
`timescale 1ns / 1ps

module psfp_frame #(
	parameter int unsigned FRAME_BYTES = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             rx_byte,
	output psfp_pkg::frame_result_t result
);

	localparam int unsigned PW = $clog2(FRAME_BYTES);

	localparam logic [PW-1:0] SUM_HI_POS = PW'(FRAME_BYTES - 2);
	localparam logic [PW-1:0] POS_25_HI  = PW'(psfp_pkg::PM25_HI_POS);
	localparam logic [PW-1:0] POS_25_LO  = PW'(psfp_pkg::PM25_LO_POS);
	localparam logic [PW-1:0] POS_10_HI  = PW'(psfp_pkg::PM10_HI_POS);
	localparam logic [PW-1:0] POS_10_LO  = PW'(psfp_pkg::PM10_LO_POS);

	logic          in_frame_q;
	logic [PW-1:0] pos_q;
	logic [15:0]   sum_q;
	logic [15:0]   pend_25_q;
	logic [15:0]   pend_10_q;
	logic [7:0]    sum_hi_q;
	logic [15:0]   stored_25_q;
	logic [15:0]   stored_10_q;

	logic is_body;
	logic is_sum_hi;
	logic is_last;
	logic sum_match;

	assign is_body   = in_frame_q && (pos_q < SUM_HI_POS);
	assign is_sum_hi = in_frame_q && (pos_q == SUM_HI_POS);
	assign is_last   = in_frame_q && (pos_q > SUM_HI_POS);
	assign sum_match = ({sum_hi_q, rx_byte} == sum_q);

	always_comb begin
		result.done  = take && is_last;
		result.ok    = sum_match;
		result.pm2_5 = sum_match ? pend_25_q : stored_25_q;
		result.pm10  = sum_match ? pend_10_q : stored_10_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			pos_q       <= '0;
			sum_q       <= '0;
			pend_25_q   <= '0;
			pend_10_q   <= '0;
			sum_hi_q    <= '0;
			stored_25_q <= '0;
			stored_10_q <= '0;
		end else if (take) begin
			if (!in_frame_q) begin
				if (rx_byte == psfp_pkg::START_MARKER) begin
					in_frame_q <= 1'b1;
					pos_q      <= PW'(1);
					sum_q      <= {8'h00, rx_byte};
					pend_25_q  <= '0;
					pend_10_q  <= '0;
					sum_hi_q   <= '0;
				end
			end else if (is_body) begin
				sum_q <= sum_q + {8'h00, rx_byte};
				pos_q <= pos_q + PW'(1);
				if (pos_q == POS_25_HI) pend_25_q[15:8] <= rx_byte;
				if (pos_q == POS_25_LO) pend_25_q[7:0]  <= rx_byte;
				if (pos_q == POS_10_HI) pend_10_q[15:8] <= rx_byte;
				if (pos_q == POS_10_LO) pend_10_q[7:0]  <= rx_byte;
			end else if (is_sum_hi) begin
				sum_hi_q <= rx_byte;
				pos_q    <= pos_q + PW'(1);
			end else begin
				if (sum_match) begin
					stored_25_q <= pend_25_q;
					stored_10_q <= pend_10_q;
				end
				in_frame_q <= 1'b0;
				pos_q      <= '0;
				sum_q      <= '0;
			end
		end
	end

endmodule

FILE: rtl/psfp_out.sv
`timescale 1ns / 1ps

module psfp_out (
	input  logic                    clk,
	input  logic                    arst_n,
	input  psfp_pkg::frame_result_t result,
	output logic                    free,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    frame_ok,
	output logic [15:0]             pm2_5_value,
	output logic [15:0]             pm10_value
);

	logic        valid_q;
	logic        ok_q;
	logic [15:0] pm25_q;
	logic [15:0] pm10_q;

	assign free        = !valid_q || out_ready;
	assign out_valid   = valid_q;
	assign frame_ok    = ok_q;
	assign pm2_5_value = pm25_q;
	assign pm10_value  = pm10_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ok_q    <= 1'b0;
			pm25_q  <= '0;
			pm10_q  <= '0;
		end else if (free) begin
			valid_q <= result.done;
			if (result.done) begin
				ok_q   <= result.ok;
				pm25_q <= result.pm2_5;
				pm10_q <= result.pm10;
			end
		end
	end

endmodule

FILE: rtl/particle_sensor_frame_parser_unit.sv
`timescale 1ns / 1ps

// Parses a particulate sensor's serial frames one byte per request, one request
// per clock. Bytes are dropped until the start marker 0x42, which opens a frame of
// FRAME_BYTES bytes; the first FRAME_BYTES-2 bytes are summed modulo 2^16 and
// checked against the big-endian checksum in the last two. Each completed frame
// gives one result in the cycle after its last byte is taken: the checksum
// verdict and the PM2.5 (bytes 6-7) and PM10 (bytes 8-9) readings of the last
// good frame, zero until one arrives. The frame state updates with each byte
// taken and the result sits in one output register, so input stalls only while
// that register holds a result that is not taken.

module particle_sensor_frame_parser_unit #(
	parameter int unsigned FRAME_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_ok,
	output logic [15:0] pm2_5_value,
	output logic [15:0] pm10_value
);

	psfp_pkg::frame_result_t result;
	logic                    free;

	assign in_ready = free;

	psfp_frame #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (in_valid && free),
		.rx_byte(rx_byte),
		.result (result)
	);

	psfp_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.result     (result),
		.free       (free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_ok   (frame_ok),
		.pm2_5_value(pm2_5_value),
		.pm10_value (pm10_value)
	);

endmodule

FILE: rtl/psfp_checker.sv
`timescale 1ns / 1ps

module psfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic        frame_ok,
	input logic [15:0] pm2_5_value,
	input logic [15:0] pm10_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_ok)
			&& $stable(pm2_5_value) && $stable(pm10_value))
		else $error("result changed while stalled");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result stalled");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
		else $error("result without an accepted request");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind particle_sensor_frame_parser_unit psfp_checker u_psfp_checker (.*);

FILE: sim/frame_result_checker.sv
`timescale 1ns / 1ps

module frame_result_checker #(
	parameter int unsigned FRAME_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        frame_ok,
	input  logic [15:0] pm2_5_value,
	input  logic [15:0] pm10_value,
	output int          mismatches,
	output int          expected_left
);

	typedef struct packed {
		logic        ok;
		logic [15:0] pm2_5;
		logic [15:0] pm10;
	} reading_t;

	reading_t    readings_q[$];
	reading_t    want;
	logic        collecting = 1'b0;
	logic [5:0]  next_pos = '0;
	logic [15:0] sum_acc = '0;
	logic [15:0] pm25_acc = '0;
	logic [15:0] pm10_acc = '0;
	logic [7:0]  sum_hi = '0;
	logic [15:0] pm25_keep = '0;
	logic [15:0] pm10_keep = '0;
	int          bad_count = 0;

	assign mismatches = bad_count;

	task automatic absorb_byte(input logic [7:0] b);
		int unsigned at;
		reading_t    r;
		at = next_pos;
		if (!collecting) begin
			if (b == psfp_pkg::START_MARKER) begin
				collecting = 1'b1;
				next_pos = 6'd1;
				sum_acc = 16'(b);
				pm25_acc = '0;
				pm10_acc = '0;
				sum_hi = '0;
			end
		end else if (at < FRAME_BYTES - 2) begin
			sum_acc = sum_acc + 16'(b);
			if (at == psfp_pkg::PM25_HI_POS) pm25_acc[15:8] = b;
			else if (at == psfp_pkg::PM25_LO_POS) pm25_acc[7:0] = b;
			else if (at == psfp_pkg::PM10_HI_POS) pm10_acc[15:8] = b;
			else if (at == psfp_pkg::PM10_LO_POS) pm10_acc[7:0] = b;
			next_pos = next_pos + 6'd1;
		end else if (at == FRAME_BYTES - 2) begin
			sum_hi = b;
			next_pos = next_pos + 6'd1;
		end else begin
			r.ok = ({sum_hi, b} == sum_acc);
			if (r.ok) begin
				pm25_keep = pm25_acc;
				pm10_keep = pm10_acc;
			end
			r.pm2_5 = pm25_keep;
			r.pm10 = pm10_keep;
			readings_q.push_back(r);
			collecting = 1'b0;
			next_pos = '0;
			sum_acc = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting = 1'b0;
			next_pos = '0;
			sum_acc = '0;
			pm25_acc = '0;
			pm10_acc = '0;
			sum_hi = '0;
			pm25_keep = '0;
			pm10_keep = '0;
			readings_q.delete();
			expected_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (readings_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected result: ok %0b pm2.5 %0d pm10 %0d",
							frame_ok, pm2_5_value, pm10_value);
				end else begin
					want = readings_q.pop_front();
					if (frame_ok !== want.ok || pm2_5_value !== want.pm2_5 ||
						pm10_value !== want.pm10) begin
						bad_count++;
						if (bad_count <= 10)
							$display("result mismatch: expected ok %0b pm2.5 %0d pm10 %0d, got ok %0b pm2.5 %0d pm10 %0d",
								want.ok, want.pm2_5, want.pm10,
								frame_ok, pm2_5_value, pm10_value);
					end
				end
			end
			if (in_valid && in_ready) absorb_byte(rx_byte);
			expected_left <= readings_q.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned FRAME_LEN = 32;
	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        frame_ok;
	logic [15:0] pm2_5_value;
	logic [15:0] pm10_value;
	int          mismatches;
	int          expected_left;

	bit          calm = 1'b0;
	int          ready_hold = 0;
	int          ready_roll;
	int          idle_cycles;
	int          bytes_sent = 0;
	int          roll;
	int          span;

	particle_sensor_frame_parser_unit #(
		.FRAME_BYTES(FRAME_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_ok(frame_ok),
		.pm2_5_value(pm2_5_value),
		.pm10_value(pm10_value)
	);

	frame_result_checker #(
		.FRAME_BYTES(FRAME_LEN)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_ok(frame_ok),
		.pm2_5_value(pm2_5_value),
		.pm10_value(pm10_value),
		.mismatches(mismatches),
		.expected_left(expected_left)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			out_ready <= (ready_roll < 65);
			if (ready_roll < 65) ready_hold <= $urandom_range(0, 20);
			else if (ready_roll < 92) ready_hold <= $urandom_range(0, 3);
			else ready_hold <= $urandom_range(10, 60);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [15:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h0000;
		if (r == 1) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] non_marker();
		logic [7:0] b;
		do b = 8'($urandom); while (b == psfp_pkg::START_MARKER);
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
	endtask

	// fill: 0 random, 1 zeros, 2 all ones, 3 marker-heavy
	task automatic send_frame(input logic [15:0] pm25, input logic [15:0] pm10,
		input bit corrupt, input int fill);
		logic [7:0]  fb [FRAME_LEN];
		logic [15:0] s;
		int          k;
		int          bit_at;
		for (k = 1; k < FRAME_LEN; k++) begin
			case (fill)
				1: fb[k] = 8'h00;
				2: fb[k] = 8'hFF;
				3: fb[k] = ($urandom_range(0, 1) == 0) ? psfp_pkg::START_MARKER :
					8'($urandom);
				default: fb[k] = 8'($urandom);
			endcase
		end
		fb[0] = psfp_pkg::START_MARKER;
		fb[psfp_pkg::PM25_HI_POS] = pm25[15:8];
		fb[psfp_pkg::PM25_LO_POS] = pm25[7:0];
		fb[psfp_pkg::PM10_HI_POS] = pm10[15:8];
		fb[psfp_pkg::PM10_LO_POS] = pm10[7:0];
		s = '0;
		for (k = 0; k < FRAME_LEN - 2; k++) s = s + 16'(fb[k]);
		fb[FRAME_LEN - 2] = s[15:8];
		fb[FRAME_LEN - 1] = s[7:0];
		if (corrupt) begin
			k = $urandom_range(1, FRAME_LEN - 1);
			bit_at = $urandom_range(0, 7);
			fb[k][bit_at] = ~fb[k][bit_at];
		end
		for (k = 0; k < FRAME_LEN; k++) send_byte(fb[k], pick_gap());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = 1'b1;
		send_byte(8'h00, 0);
		send_byte(8'hFF, 0);
		send_byte(8'h41, 0);
		send_byte(8'h43, 0);
		send_frame(16'hFFFF, 16'hFFFF, 1'b1, 3);
		calm = 1'b0;
		send_frame(16'hFFFF, 16'h0000, 1'b0, 2);
		send_frame(16'h0000, 16'hFFFF, 1'b0, 1);
		send_frame(16'h1234, 16'hABCD, 1'b1, 0);
		wait_drained();

		while (bytes_sent < 800) begin
			calm = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 78) begin
				send_frame(pick_word(), pick_word(), $urandom_range(0, 4) == 0,
					$urandom_range(0, 3));
			end else if (roll < 90) begin
				repeat ($urandom_range(1, 6)) send_byte(non_marker(), pick_gap());
			end else begin
				// truncated frame, then filler until the parser is back to hunting
				span = $urandom_range(0, FRAME_LEN - 3);
				send_byte(psfp_pkg::START_MARKER, pick_gap());
				repeat (span) send_byte(8'($urandom), pick_gap());
				repeat (FRAME_LEN) send_byte(non_marker(), pick_gap());
			end
			if (roll >= 96) wait_drained();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_left == 0) $display("testbench OK");
		else $display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: particle_sensor_frame_parser_unit.f
rtl/psfp_pkg.sv
rtl/psfp_frame.sv
rtl/psfp_out.sv
rtl/particle_sensor_frame_parser_unit.sv
rtl/psfp_checker.sv
sim/frame_result_checker.sv
sim/testbench.sv
